// ===== src/gdad_pkg.sv =====
// Shared types, constants and the month-length function for the date adder.
`timescale 1ns / 1ps
`default_nettype none
package gdad_pkg;

    localparam int DayW    = 5;
    localparam int MonthW  = 4;
    localparam int YearW   = 14;
    localparam int AddW    = 15;
    localparam int RemW    = 16;
    localparam int YearIntW = YearW + 1;
    localparam int InDataW  = 40;
    localparam int OutDataW = 24;

    localparam logic [YearW-1:0]    YearOutMax = 14'd16383;
    localparam logic [YearW-1:0]    Cycle400   = 14'd400;
    localparam logic [MonthW-1:0]   MonthJan   = 4'd1;
    localparam logic [MonthW-1:0]   MonthFeb   = 4'd2;
    localparam logic [MonthW-1:0]   MonthDec   = 4'd12;

    typedef logic [2:0] pc_t;

    localparam pc_t PcLoad  = 3'd0;
    localparam pc_t PcMod   = 3'd1;
    localparam pc_t PcSum   = 3'd2;
    localparam pc_t PcRewind = 3'd3;
    localparam pc_t PcWalk  = 3'd4;
    localparam pc_t PcEmit  = 3'd5;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SUB400 = 3'd1,
        OP_ADDMON = 3'd2,
        OP_SETM1  = 3'd3,
        OP_WALK   = 3'd4,
        OP_EMIT   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS   = 3'd0,
        C_IN_VALID = 3'd1,
        C_GE400    = 3'd2,
        C_LT_SMON  = 3'd3,
        C_GT_LEN   = 3'd4,
        C_OUT_FREE = 3'd5
    } cond_t;

    // op runs only when cond holds; then branch to pc_true, else to pc_false
    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   pc_true;
        pc_t   pc_false;
    } ctl_word_t;

    typedef struct packed {
        logic ge400;
        logic lt_smon;
        logic gt_len;
    } dp_flags_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            MonthFeb:                                  len = leap ? 5'd29 : 5'd28;
            default:                                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== src/gdad_rom.sv =====
// Microcode ROM: one control word per program step.
`timescale 1ns / 1ps
`default_nettype none
module gdad_rom
    import gdad_pkg::*;
(
    input  wire pc_t       pc,
    output ctl_word_t      ctl
);

    always_comb begin
        case (pc)
            PcLoad:   ctl = '{op: OP_LOAD,   cond: C_IN_VALID, pc_true: PcMod,    pc_false: PcLoad};
            PcMod:    ctl = '{op: OP_SUB400, cond: C_GE400,    pc_true: PcMod,    pc_false: PcSum};
            PcSum:    ctl = '{op: OP_ADDMON, cond: C_LT_SMON,  pc_true: PcSum,    pc_false: PcRewind};
            PcRewind: ctl = '{op: OP_SETM1,  cond: C_ALWAYS,   pc_true: PcWalk,   pc_false: PcWalk};
            PcWalk:   ctl = '{op: OP_WALK,   cond: C_GT_LEN,   pc_true: PcWalk,   pc_false: PcEmit};
            PcEmit:   ctl = '{op: OP_EMIT,   cond: C_OUT_FREE, pc_true: PcLoad,   pc_false: PcEmit};
            default:  ctl = '{op: OP_SETM1,  cond: C_ALWAYS,   pc_true: PcLoad,   pc_false: PcLoad};
        endcase
    end

endmodule
`default_nettype wire

// ===== src/gdad_dp.sv =====
// Datapath: day remainder, month and year counters, year-mod-400 tracker.
`timescale 1ns / 1ps
`default_nettype none
module gdad_dp
    import gdad_pkg::*;
(
    input  wire                  aclk,
    input  wire op_t             op,
    input  wire                  exec,
    input  wire [DayW-1:0]       in_day,
    input  wire [MonthW-1:0]     in_month,
    input  wire [YearW-1:0]      in_year,
    input  wire [AddW-1:0]       in_add,
    output dp_flags_t            flags,
    output logic [DayW-1:0]      res_day,
    output logic [MonthW-1:0]    res_month,
    output logic [YearW-1:0]     res_year,
    output logic                 res_ovf
);

    logic [RemW-1:0]     rem_reg,   rem_next;
    logic [MonthW-1:0]   month_reg, month_next;
    logic [MonthW-1:0]   smon_reg,  smon_next;
    logic [YearIntW-1:0] year_reg,  year_next;
    logic [YearW-1:0]    y400_reg,  y400_next;

    logic            leap;
    logic [DayW-1:0] len;

    // y400 holds year mod 400 once the reduction loop has finished
    assign leap = (y400_reg == '0) ||
                  (y400_reg != 14'd100 && y400_reg != 14'd200 && y400_reg != 14'd300 &&
                   year_reg[1:0] == 2'b00);
    assign len  = month_len(month_reg, leap);

    assign flags.ge400   = (y400_reg >= Cycle400);
    assign flags.lt_smon = (month_reg < smon_reg);
    assign flags.gt_len  = (rem_reg > RemW'(len));

    always_comb begin
        rem_next   = rem_reg;
        month_next = month_reg;
        smon_next  = smon_reg;
        year_next  = year_reg;
        y400_next  = y400_reg;
        if (exec) begin
            case (op)
                OP_LOAD: begin
                    rem_next   = RemW'(in_add) + RemW'(in_day);
                    month_next = MonthJan;
                    smon_next  = in_month;
                    year_next  = YearIntW'(in_year);
                    y400_next  = in_year;
                end
                OP_SUB400: begin
                    y400_next = y400_reg - Cycle400;
                end
                OP_ADDMON: begin
                    rem_next   = rem_reg + RemW'(len);
                    month_next = month_reg + MonthW'(1);
                end
                OP_SETM1: begin
                    month_next = MonthJan;
                end
                OP_WALK: begin
                    rem_next = rem_reg - RemW'(len);
                    if (month_reg == MonthDec) begin
                        // roll into January of the next year
                        month_next = MonthJan;
                        year_next  = year_reg + YearIntW'(1);
                        y400_next  = (y400_reg == Cycle400 - YearW'(1)) ? '0
                                                                        : y400_reg + YearW'(1);
                    end else begin
                        month_next = month_reg + MonthW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        month_reg <= month_next;
        smon_reg  <= smon_next;
        year_reg  <= year_next;
        y400_reg  <= y400_next;
    end

    assign res_day   = rem_reg[DayW-1:0];
    assign res_month = month_reg;
    assign res_ovf   = year_reg[YearIntW-1];
    assign res_year  = year_reg[YearIntW-1] ? YearOutMax : year_reg[YearW-1:0];

endmodule
`default_nettype wire

// ===== src/gregorian_date_add_days.sv =====
// Top level: microcode sequencer, datapath and output word register.
// Sequence: a load step, the year-mod-400 steps, the month-sum steps, a rewind step,
// one step per month walked, and an emit step that waits for the output register.
// Throughput: one word at a time; the next input can be taken from the cycle after emit,
// while the result may still wait in the output register.
// Reset: aresetn (synchronous, active low) returns the step counter to the load
// step and drops m_tvalid; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_add_days
    import gdad_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year, [37:23] days_to_add
    input  wire [InDataW-1:0]     s_tdata,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // [4:0] result_day, [8:5] result_month, [22:9] result_year, [23] year_overflow
    output logic [OutDataW-1:0]   m_tdata
);

    pc_t       pc_reg, pc_next;
    ctl_word_t ctl;
    dp_flags_t flags;
    logic      cond_ok;
    logic      out_free;

    logic [DayW-1:0]   res_day;
    logic [MonthW-1:0] res_month;
    logic [YearW-1:0]  res_year;
    logic              res_ovf;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [OutDataW-1:0] m_tdata_reg,  m_tdata_next;

    gdad_rom u_rom (
        .pc  (pc_reg),
        .ctl (ctl)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (ctl.cond)
            C_ALWAYS:   cond_ok = 1'b1;
            C_IN_VALID: cond_ok = s_tvalid;
            C_GE400:    cond_ok = flags.ge400;
            C_LT_SMON:  cond_ok = flags.lt_smon;
            C_GT_LEN:   cond_ok = flags.gt_len;
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b0;
        endcase
    end

    assign pc_next  = cond_ok ? ctl.pc_true : ctl.pc_false;
    assign s_tready = (ctl.op == OP_LOAD);

    gdad_dp u_dp (
        .aclk      (aclk),
        .op        (ctl.op),
        .exec      (cond_ok),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .in_add    (s_tdata[37:23]),
        .flags     (flags),
        .res_day   (res_day),
        .res_month (res_month),
        .res_year  (res_year),
        .res_ovf   (res_ovf)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        // load the output word when the emit step fires
        if (ctl.op == OP_EMIT && cond_ok) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res_ovf, res_year, res_month, res_day};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= PcLoad;
            m_tvalid_reg <= 1'b0;
        end else begin
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== src/gdad_checker.sv =====
// Port-level checker for the date adder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gdad_checker
    import gdad_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire                 m_tvalid,
    input wire                 m_tready,
    input wire [OutDataW-1:0]  m_tdata
);

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: no accept on the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> m_tdata[22:9] == YearOutMax)
        else $error("overflow flag without saturated year");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:5] >= MonthJan && m_tdata[8:5] <= MonthDec)
        else $error("result month out of range");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== dv/date_sum_checker.sv =====
// Checker for the date adder: predicts each result from accepted inputs and compares.
`timescale 1ns / 1ps
module date_sum_checker
    import gdad_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    input  wire                 s_tready,
    // [4:0] start_day, [8:5] start_month, [22:9] start_year, [37:23] days_to_add
    input  wire [InDataW-1:0]   s_tdata,
    input  wire                 m_tvalid,
    input  wire                 m_tready,
    // [4:0] result_day, [8:5] result_month, [22:9] result_year, [23] year_overflow
    input  wire [OutDataW-1:0]  m_tdata,
    output int unsigned         fail_total,
    output int unsigned         awaiting
);

    typedef struct {
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
        logic              ovf;
    } date_t;

    date_t dates_due[$];
    date_t want;

    initial begin
        fail_total = 0;
        awaiting   = 0;
    end

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        logic leap;
        leap = (y % Cycle400 == 0) || (y % 100 != 0 && y % 4 == 0);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            MonthFeb:              return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Form the day-of-year ordinal, then walk months from January of the start year.
    function automatic date_t add_days_to_date(input logic [InDataW-1:0] w);
        date_t       r;
        int unsigned yr;
        int unsigned rem;
        int unsigned m;
        yr  = 32'(w[22:9]);
        rem = 32'(w[37:23]) + 32'(w[4:0]);
        for (m = MonthJan; m < 32'(w[8:5]); m++)
            rem += month_days(m, yr);
        m = MonthJan;
        while (rem > month_days(m, yr)) begin
            rem -= month_days(m, yr);
            m++;
            if (m > MonthDec) begin
                m = MonthJan;
                yr++;
            end
        end
        r.ovf   = (yr > YearOutMax);
        r.year  = r.ovf ? YearOutMax : yr[YearW-1:0];
        r.day   = rem[DayW-1:0];
        r.month = m[MonthW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned exp_val,
                                   input int unsigned got_val);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                 exp_val, got_val);
        fail_total++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            // retire the result word before queueing a new prediction
            if (m_tvalid && m_tready) begin
                if (dates_due.size() == 0) begin
                    report_mismatch("result word with none pending", 0, m_tdata);
                end else begin
                    want = dates_due.pop_front();
                    if (m_tdata[4:0] != want.day)
                        report_mismatch("result_day", want.day, m_tdata[4:0]);
                    if (m_tdata[8:5] != want.month)
                        report_mismatch("result_month", want.month, m_tdata[8:5]);
                    if (m_tdata[22:9] != want.year)
                        report_mismatch("result_year", want.year, m_tdata[22:9]);
                    if (m_tdata[23] != want.ovf)
                        report_mismatch("year_overflow", want.ovf, m_tdata[23]);
                end
            end
            if (s_tvalid && s_tready)
                dates_due.push_back(add_days_to_date(s_tdata));
            awaiting <= dates_due.size();
        end
    end

endmodule

// ===== dv/gregorian_date_add_days_tb.sv =====
// Testbench top for the date adder: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module gregorian_date_add_days_tb;
    import gdad_pkg::*;

    localparam int StallLimit = 20000;
    localparam int DrainCycles = 60;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    int unsigned fail_total;
    int unsigned awaiting;
    int unsigned s_idle_pct;
    int unsigned m_stall_pct;
    int unsigned quiet_cycles;

    gregorian_date_add_days DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    date_sum_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_total (fail_total),
        .awaiting   (awaiting)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // Abort when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_date(input int unsigned day, input int unsigned mon,
                             input int unsigned yr, input int unsigned add);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, add[AddW-1:0], yr[YearW-1:0], mon[MonthW-1:0], day[DayW-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    initial begin
        int unsigned day;
        int unsigned mon;
        int unsigned yr;
        int unsigned add;
        int unsigned pick;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        quiet_cycles = 0;
        s_idle_pct   = 0;
        m_stall_pct  = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, leap rules, odd months and days, overflow
        send_date(1, MonthJan, 1, 0);
        send_date(0, 0, 2023, 0);
        send_date(0, MonthJan, 2023, 0);
        send_date(31, MonthFeb, 2023, 0);
        send_date(29, MonthFeb, 2000, 0);
        send_date(28, MonthFeb, 1900, 1);
        send_date(28, MonthFeb, 2100, 1);
        send_date(28, MonthFeb, 2400, 1);
        send_date(28, MonthFeb, 0, 1);
        send_date(31, MonthDec, 1999, 1);
        send_date(15, 13, 2024, 10);
        send_date(15, 14, 2023, 400);
        send_date(0, 15, 0, 0);
        send_date(1, MonthJan, 1, 32767);
        send_date(31, MonthDec, 9999, 32767);
        send_date(1, MonthJan, 16383, 0);
        send_date(31, MonthDec, 16383, 1);
        send_date(31, 15, 16383, 32767);
        send_date(31, MonthDec, 16300, 32767);
        send_date(30, 11, 8191, 16384);

        // random: phases of none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            s_idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 31 : 0;
            m_stall_pct = (ph == 2) ? 65 : (ph == 3) ? 31 : 0;
            for (int i = 0; i < 120; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    mon = $urandom_range(MonthJan, MonthDec);
                    day = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 31)
                                                       : $urandom_range(1, 28);
                    case ($urandom_range(0, 9))
                        0:       yr = $urandom_range(16200, 16383);
                        1:       yr = $urandom_range(0, 163) * 100;
                        default: yr = $urandom_range(1, 9999);
                    endcase
                end else begin
                    day = $urandom_range(0, 31);
                    mon = $urandom_range(0, 15);
                    yr  = $urandom_range(0, 16383);
                end
                // keep most walks short; a quarter span the full count
                add = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, 1500);
                send_date(day, mon, yr, add);
            end
        end
        s_tvalid <= 1'b0;

        // let the last accepted word show up in the pending count
        @(posedge aclk);
        while (awaiting != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        if (fail_total == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
src/gdad_pkg.sv
src/gdad_rom.sv
src/gdad_dp.sv
src/gregorian_date_add_days.sv
src/gdad_checker.sv
dv/date_sum_checker.sv
dv/gregorian_date_add_days_tb.sv
